// ----- rtl/wh2d_pkg.sv -----
`timescale 1ns / 1ps

package wh2d_pkg;

  localparam int VAL_W      = 32;   // Q16.16 coordinates, edges and weight
  localparam int NB_W       = 7;    // bin count register width
  localparam int ACC_W      = 48;   // Q32.16 cell sum
  localparam int BIN_W      = 6;    // bin index fields on the ports
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 64;

  localparam int DEF_MAX_BINS_X = 64;
  localparam int DEF_MAX_BINS_Y = 64;

  // Quotient is below the bin count, so one quotient bit per bin-count bit.
  localparam int DIV_STEPS = NB_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_BINS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_BINS = 3'd5;

  localparam logic             REQ_FILL = 1'b0;
  localparam logic             REQ_READ = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic load;      // capture the input transaction
    logic prep;      // offsets, span and range checks
    logic mul;       // scale by bin count, load divider
    logic div_step;  // one quotient bit
    logic rd;        // read the cell
    logic acc;       // accumulate, write back, load output register
    logic clr;       // clearing write after reset
  } cmd_t;

  typedef struct packed {
    logic hit;       // both axes land in a bin
    logic out_free;  // output register can take a result this cycle
    logic clr_last;  // clearing pass on its last entry
  } sts_t;

endpackage

// ----- rtl/weighted_histogram_2d.sv -----
`timescale 1ns / 1ps

// Weighted 2D histogram over uniform bins. A fill transaction (tuser 0) bins x and y as
// floor((v - low) * bins / (high - low)) per axis and adds the Q16.16 weight to that
// cell with a 48-bit saturating sum; a read transaction (tuser 1) returns one cell.
// Every transaction gives exactly one result. Transactions are handled one at a time:
// a fill runs a range check and a scaling multiply, then a restoring divider, one
// quotient bit per cycle, both axes in parallel, then cell read and write-back, both
// skipped when it lands outside the axes; a read only reads the cell. Either one
// stalls only while the previous result still sits unaccepted in the output register.
// The output register lets the next transaction in while a result waits. After reset
// the cell memory is swept to zero, one cell per cycle, over 2^(clog2(MAX_BINS_X) +
// clog2(MAX_BINS_Y)) cells (4096 at the defaults); in_tready stays low during the
// sweep, configuration writes are taken as usual. Write configuration only while
// the block is idle.
module weighted_histogram_2d #(
  parameter int MAX_BINS_X = wh2d_pkg::DEF_MAX_BINS_X,
  parameter int MAX_BINS_Y = wh2d_pkg::DEF_MAX_BINS_Y
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wh2d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wh2d_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // xval[31:0], yval[63:32], weight[95:64], read_bin_x[101:96], read_bin_y[107:102]
  input  logic [wh2d_pkg::IN_DATA_W-1:0]    in_tdata,
  // req_type
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cell_sum[47:0], in_range[48], out_bin_x[54:49], out_bin_y[60:55], saturated[61]
  output logic [wh2d_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import wh2d_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  wh2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  wh2d_datapath #(
    .MAX_BINS_X (MAX_BINS_X),
    .MAX_BINS_Y (MAX_BINS_Y)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/wh2d_axis.sv -----
`timescale 1ns / 1ps

module wh2d_axis (
  input  logic                          clk,
  input  logic                          prep,
  input  logic                          mul,
  input  logic                          div_step,
  input  logic [wh2d_pkg::VAL_W-1:0]    v,
  input  logic [wh2d_pkg::VAL_W-1:0]    lo,
  input  logic [wh2d_pkg::VAL_W-1:0]    hi,
  input  logic [wh2d_pkg::NB_W-1:0]     nb,
  output logic                          hit,
  output logic [wh2d_pkg::NB_W-1:0]     q
);
  import wh2d_pkg::*;

  localparam int PROD_W = VAL_W + NB_W;

  logic signed [VAL_W:0]   diff, span;
  logic                    hit_nxt;
  logic [VAL_W-1:0]        diff_r, span_r;
  logic                    hit_r;
  logic [PROD_W-1:0]       prod;
  logic [VAL_W-1:0]        rem_r, rem_nxt;
  logic [NB_W-1:0]         nlo_r, q_r;
  logic [VAL_W:0]          trial, trial_sub;
  logic                    ge;

  assign diff    = $signed({v[VAL_W-1], v}) - $signed({lo[VAL_W-1], lo});
  assign span    = $signed({hi[VAL_W-1], hi}) - $signed({lo[VAL_W-1], lo});
  // diff < span keeps the quotient below nb, so the divider needs NB_W bits only
  assign hit_nxt = (nb != '0) && (span > 0) && (diff >= 0) && (diff < span);

  assign prod = PROD_W'(diff_r) * PROD_W'(nb);

  // restoring division, remainder always below the span
  assign trial     = {rem_r, nlo_r[NB_W-1]};
  assign trial_sub = trial - {1'b0, span_r};
  assign ge        = (trial >= {1'b0, span_r});
  assign rem_nxt   = ge ? trial_sub[VAL_W-1:0] : trial[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (prep) begin
      diff_r <= diff[VAL_W-1:0];
      span_r <= span[VAL_W-1:0];
      hit_r  <= hit_nxt;
    end
    if (mul) begin
      rem_r <= prod[PROD_W-1:NB_W];
      nlo_r <= prod[NB_W-1:0];
      q_r   <= '0;
    end else if (div_step) begin
      rem_r <= rem_nxt;
      nlo_r <= {nlo_r[NB_W-2:0], 1'b0};
      q_r   <= {q_r[NB_W-2:0], ge};
    end
  end

  assign hit = hit_r;
  assign q   = q_r;

endmodule

// ----- rtl/wh2d_datapath.sv -----
`timescale 1ns / 1ps

module wh2d_datapath #(
  parameter int MAX_BINS_X = wh2d_pkg::DEF_MAX_BINS_X,
  parameter int MAX_BINS_Y = wh2d_pkg::DEF_MAX_BINS_Y
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wh2d_pkg::cmd_t                    cmd,
  output wh2d_pkg::sts_t                    sts,
  input  logic                              cfg_valid,
  input  logic [wh2d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wh2d_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [wh2d_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wh2d_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import wh2d_pkg::*;

  localparam int XW    = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
  localparam int YW    = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;

  // configuration
  logic [VAL_W-1:0] x_low_r, x_high_r, y_low_r, y_high_r;
  logic [NB_W-1:0]  x_bins_r, y_bins_r;
  logic [NB_W-1:0]  nbx, nby;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= '0;
      x_high_r <= VAL_W'(4194304);
      x_bins_r <= NB_W'(64);
      y_low_r  <= '0;
      y_high_r <= VAL_W'(4194304);
      y_bins_r <= NB_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_LOW:  x_low_r  <= cfg_data[VAL_W-1:0];
        REG_X_HIGH: x_high_r <= cfg_data[VAL_W-1:0];
        REG_X_BINS: x_bins_r <= cfg_data[NB_W-1:0];
        REG_Y_LOW:  y_low_r  <= cfg_data[VAL_W-1:0];
        REG_Y_HIGH: y_high_r <= cfg_data[VAL_W-1:0];
        REG_Y_BINS: y_bins_r <= cfg_data[NB_W-1:0];
        default: ;
      endcase
    end
  end

  assign nbx = (int'(x_bins_r) > MAX_BINS_X) ? NB_W'(MAX_BINS_X) : x_bins_r;
  assign nby = (int'(y_bins_r) > MAX_BINS_Y) ? NB_W'(MAX_BINS_Y) : y_bins_r;

  // captured transaction
  logic             is_read_r;
  logic [VAL_W-1:0] xval_r, yval_r, weight_r;
  logic [BIN_W-1:0] rbx_r, rby_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_read_r <= in_tuser;
      xval_r    <= in_tdata[31:0];
      yval_r    <= in_tdata[63:32];
      weight_r  <= in_tdata[95:64];
      rbx_r     <= in_tdata[101:96];
      rby_r     <= in_tdata[107:102];
    end
  end

  logic            hit_x, hit_y;
  logic [NB_W-1:0] qx, qy;

  wh2d_axis u_axis_x (
    .clk(clk), .prep(cmd.prep), .mul(cmd.mul), .div_step(cmd.div_step),
    .v(xval_r), .lo(x_low_r), .hi(x_high_r), .nb(nbx), .hit(hit_x), .q(qx)
  );

  wh2d_axis u_axis_y (
    .clk(clk), .prep(cmd.prep), .mul(cmd.mul), .div_step(cmd.div_step),
    .v(yval_r), .lo(y_low_r), .hi(y_high_r), .nb(nby), .hit(hit_y), .q(qy)
  );

  // cell store
  logic [ACC_W-1:0] mem [DEPTH];
  logic [ACC_W-1:0] mem_q_r;
  logic [AW-1:0]    cell_addr, wr_addr, clr_addr_r;
  logic [ACC_W-1:0] wr_data;
  logic             wr_en;
  logic             fill_hit;

  assign fill_hit  = hit_x & hit_y;
  assign cell_addr = is_read_r ? {XW'(rbx_r), YW'(rby_r)} : {XW'(qx), YW'(qy)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // saturating accumulate
  logic signed [ACC_W:0]   sum_w;
  logic                    ovf;
  logic signed [ACC_W-1:0] clipped;

  assign sum_w   = $signed({mem_q_r[ACC_W-1], mem_q_r})
                 + $signed({{(ACC_W+1-VAL_W){weight_r[VAL_W-1]}}, weight_r});
  assign ovf     = sum_w[ACC_W] ^ sum_w[ACC_W-1];
  assign clipped = ovf ? (sum_w[ACC_W] ? ACC_MIN : ACC_MAX) : sum_w[ACC_W-1:0];

  assign wr_en   = cmd.clr | (cmd.acc & ~is_read_r & fill_hit);
  assign wr_addr = cmd.clr ? clr_addr_r : cell_addr;
  assign wr_data = cmd.clr ? '0 : clipped;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      mem_q_r <= mem[cell_addr];
    end
  end

  // result
  logic             read_ok, res_ok, res_sat;
  logic [ACC_W-1:0] res_sum;
  logic [BIN_W-1:0] res_bx, res_by;

  assign read_ok = ({1'b0, rbx_r} < nbx) && ({1'b0, rby_r} < nby);

  always_comb begin
    if (is_read_r) begin
      res_ok  = read_ok;
      res_sum = read_ok ? mem_q_r : '0;
      res_bx  = rbx_r;
      res_by  = rby_r;
      res_sat = 1'b0;
    end else begin
      res_ok  = fill_hit;
      res_sum = fill_hit ? clipped : '0;
      res_bx  = fill_hit ? qx[BIN_W-1:0] : '0;
      res_by  = fill_hit ? qy[BIN_W-1:0] : '0;
      res_sat = fill_hit & ovf;
    end
  end

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      out_data_r <= {2'b00, res_sat, res_by, res_bx, res_ok, res_sum};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  assign sts.hit      = fill_hit;
  assign sts.out_free = ~out_valid_r | out_tready;
  assign sts.clr_last = &clr_addr_r;

endmodule

// ----- rtl/wh2d_ctrl.sv -----
`timescale 1ns / 1ps

module wh2d_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tuser,
  output logic            in_tready,
  output wh2d_pkg::cmd_t  cmd,
  input  wh2d_pkg::sts_t  sts
);
  import wh2d_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_RD,
    ST_ACC
  } state_t;

  state_t               state_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: if (sts.clr_last) state_r <= ST_IDLE;
        ST_IDLE: begin
          if (accept) state_r <= (in_tuser == REQ_READ) ? ST_RD : ST_PREP;
        end
        ST_PREP: state_r <= ST_MUL;
        ST_MUL: begin
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_r <= sts.hit ? ST_RD : ST_ACC;
          end
        end
        ST_RD: state_r <= ST_ACC;
        ST_ACC: if (sts.out_free) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.prep     = (state_r == ST_PREP);
    cmd.mul      = (state_r == ST_MUL);
    cmd.div_step = (state_r == ST_DIV);
    cmd.rd       = (state_r == ST_RD);
    cmd.acc      = (state_r == ST_ACC) & sts.out_free;
    cmd.clr      = (state_r == ST_CLEAR);
  end

endmodule
